>>> rtl/pmts_pkg.sv
// package for the priority message table scheduler
// holds sizes, status codes, entry/token/update structs and the controller state type
// no dependencies
`default_nettype none

package pmts_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int SAMPLE_W = 8;
	localparam int PRIO_W   = 10;
	localparam int AGE_W    = 8;
	localparam int HOLD_W   = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic [AGE_W-1:0]  AGE_MAX    = '1;
	localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(10);

	localparam logic [STATUS_W-1:0] STS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STS_DUP  = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL = 2'd2;

	localparam logic FUNC_TICK   = 1'b0;
	localparam logic FUNC_INSERT = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [PRIO_W-1:0]   prio;
		logic                played;
		logic [AGE_W-1:0]    age;
	} entry_t;

	// scan token walking down the chain
	typedef struct packed {
		logic                active;
		logic                dup;
		logic                have_pick;
		logic [PRIO_W-1:0]   best;
		idx_t                pick;
		logic [SAMPLE_W-1:0] pick_sample;
		logic                have_del;
		idx_t                del;
	} tok_t;

	// update broadcast to every cell
	typedef struct packed {
		logic                en;
		logic                tick;
		logic                play;
		idx_t                play_idx;
		logic                del;
		idx_t                del_idx;
		logic                ins;
		idx_t                ins_idx;
		logic [SAMPLE_W-1:0] ins_sample;
		logic [PRIO_W-1:0]   ins_prio;
	} apply_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} state_t;

endpackage

`default_nettype wire

>>> rtl/pmts_cell.sv
// one table cell: holds an entry, passes the scan token to its neighbour
// depends on pmts_pkg
`default_nettype none

module pmts_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pmts_pkg::idx_t                    idx,
	input  pmts_pkg::cnt_t                    count,
	input  logic [pmts_pkg::HOLD_W-1:0]       hold,
	input  logic [pmts_pkg::SAMPLE_W-1:0]     sid,
	input  pmts_pkg::tok_t                    tok_in,
	input  pmts_pkg::apply_t                  apply,
	input  pmts_pkg::entry_t                  nbr_upd,
	output pmts_pkg::tok_t                    tok_out,
	output pmts_pkg::entry_t                  upd
);
	import pmts_pkg::*;

	entry_t            entry_q;
	entry_t            nxt;
	logic [AGE_W-1:0]  aged;
	logic              used;
	tok_t              tok_nxt;
	tok_t              tok_pay_q;
	logic              tok_act_q;

	always_comb begin
		aged = entry_q.age;
		if (entry_q.played && (entry_q.age != AGE_MAX)) begin
			aged = entry_q.age + AGE_W'(1);
		end
		used = (CNT_W'(idx) < count);

		// ageing and play flag as the update cycle sees them
		upd = entry_q;
		if (apply.tick) begin
			upd.age = aged;
		end
		if (apply.play && (apply.play_idx == idx)) begin
			upd.played = 1'b1;
		end

		nxt = upd;
		if (apply.del && (idx >= apply.del_idx)) begin
			nxt = nbr_upd;
		end
		if (apply.ins && (apply.ins_idx == idx)) begin
			nxt.sample = apply.ins_sample;
			nxt.prio   = apply.ins_prio;
			nxt.played = 1'b0;
			nxt.age    = '0;
		end

		tok_nxt     = tok_in;
		tok_nxt.dup = tok_in.dup | (used && (entry_q.sample == sid));
		if (used && !entry_q.played && (entry_q.prio > tok_in.best)) begin
			tok_nxt.have_pick   = 1'b1;
			tok_nxt.best        = entry_q.prio;
			tok_nxt.pick        = idx;
			tok_nxt.pick_sample = entry_q.sample;
		end
		if (used && (aged > hold)) begin
			tok_nxt.have_del = 1'b1;
			tok_nxt.del      = idx;
		end
	end

	always_ff @(posedge clk) begin
		if (apply.en) begin
			entry_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_act_q <= 1'b0;
		end else begin
			tok_act_q <= tok_in.active;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.active) begin
			tok_pay_q <= tok_nxt;
		end
	end

	always_comb begin
		tok_out        = tok_pay_q;
		tok_out.active = tok_act_q;
	end

endmodule

`default_nettype wire

>>> rtl/pmts_ctrl.sv
// sequencer: takes a transaction, launches the scan, applies the update, drives the result
// depends on pmts_pkg
`default_nettype none

module pmts_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic                              func,
	input  logic [pmts_pkg::SAMPLE_W-1:0]     sample_id,
	input  logic [pmts_pkg::PRIO_W-1:0]       priority_req,
	input  logic                              player_busy,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pmts_pkg::HOLD_W-1:0]       hold_ticks,
	input  pmts_pkg::tok_t                    tok_last,
	output pmts_pkg::tok_t                    tok_first,
	output pmts_pkg::apply_t                  apply,
	output pmts_pkg::cnt_t                    count,
	output logic [pmts_pkg::SAMPLE_W-1:0]     sid,
	output logic [pmts_pkg::HOLD_W-1:0]       hold,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic                              play_valid,
	output logic [pmts_pkg::SAMPLE_W-1:0]     play_id,
	output logic [pmts_pkg::STATUS_W-1:0]     insert_status,
	output logic [pmts_pkg::COUNT_W-1:0]      entry_count
);
	import pmts_pkg::*;

	state_t                state_q, state_nxt;
	logic                  start_q;
	logic                  func_q;
	logic                  busy_q;
	logic [SAMPLE_W-1:0]   sid_q;
	logic [PRIO_W-1:0]     prio_q;
	logic [HOLD_W-1:0]     hold_q;
	tok_t                  res_q;
	cnt_t                  count_q, count_nxt;
	logic                  rsp_valid_q;
	logic                  play_valid_q;
	logic [SAMPLE_W-1:0]   play_id_q;
	logic [STATUS_W-1:0]   status_q, status_nxt;
	logic [COUNT_W-1:0]    entry_count_q;
	logic                  accept;
	logic                  go;
	logic                  full;

	assign accept = req_valid && !req_stall;
	assign full   = (count_q >= CNT_W'(TABLE_DEPTH));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (req_valid) state_nxt = ST_SCAN;
			ST_SCAN:  if (tok_last.active) state_nxt = ST_APPLY;
			ST_APPLY: if (!rsp_valid_q || !rsp_stall) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != ST_IDLE);
		go        = (state_q == ST_APPLY) && (!rsp_valid_q || !rsp_stall);
	end

	always_comb begin
		apply            = '0;
		apply.en         = go;
		apply.tick       = (func_q == FUNC_TICK);
		apply.play       = apply.tick && res_q.have_pick && !busy_q;
		apply.play_idx   = res_q.pick;
		apply.del        = apply.tick && res_q.have_del;
		apply.del_idx    = res_q.del;
		apply.ins        = (func_q == FUNC_INSERT) && !res_q.dup && !full;
		apply.ins_idx    = count_q[IDX_W-1:0];
		apply.ins_sample = sid_q;
		apply.ins_prio   = prio_q;

		count_nxt = count_q;
		if (apply.ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (apply.del) begin
			count_nxt = count_q - CNT_W'(1);
		end

		status_nxt = STS_OK;
		if (func_q == FUNC_INSERT) begin
			if (res_q.dup) begin
				status_nxt = STS_DUP;
			end else if (full) begin
				status_nxt = STS_FULL;
			end
		end
	end

	always_comb begin
		tok_first        = '0;
		tok_first.active = start_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			hold_q      <= HOLD_RESET;
		end else begin
			state_q <= state_nxt;
			start_q <= accept;
			if (go) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				hold_q <= hold_ticks;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			busy_q <= player_busy;
			sid_q  <= sample_id;
			prio_q <= priority_req;
		end
		if (tok_last.active) begin
			res_q <= tok_last;
		end
		if (go) begin
			play_valid_q  <= apply.play;
			play_id_q     <= apply.play ? res_q.pick_sample : '0;
			status_q      <= status_nxt;
			entry_count_q <= COUNT_W'(count_nxt);
		end
	end

	assign cfg_ready     = 1'b1;
	assign count         = count_q;
	assign sid           = sid_q;
	assign hold          = hold_q;
	assign rsp_valid     = rsp_valid_q;
	assign play_valid    = play_valid_q;
	assign play_id       = play_id_q;
	assign insert_status = status_q;
	assign entry_count   = entry_count_q;

endmodule

`default_nettype wire

>>> rtl/priority_message_table_scheduler.sv
// top level of the priority message table scheduler: sequencer plus a chain of table cells
// depends on pmts_pkg, pmts_cell and pmts_ctrl
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  req      | req_valid/req_stall  | func, sample_id, priority_req, player_busy
//  rsp      | rsp_valid/rsp_stall  | play_valid, play_id, insert_status, entry_count
//  cfg      | cfg_valid/cfg_ready  | hold_ticks
//
// after acceptance the request side stays stalled while the scan runs and until the
// update is applied; the result is registered in the update cycle
// the scan token moves one cell per cycle down the chain
// reset clears the sequencer, the fill count and the token flags; the hold register returns to 10
// a stalled result waits in the output register; the next request is taken meanwhile,
// and only its update cycle waits for the output register to drain
`default_nettype none

module priority_message_table_scheduler (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic                              func,
	input  logic [pmts_pkg::SAMPLE_W-1:0]     sample_id,
	input  logic [pmts_pkg::PRIO_W-1:0]       priority_req,
	input  logic                              player_busy,
	// result channel
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic                              play_valid,
	output logic [pmts_pkg::SAMPLE_W-1:0]     play_id,
	output logic [pmts_pkg::STATUS_W-1:0]     insert_status,
	output logic [pmts_pkg::COUNT_W-1:0]      entry_count,
	// configuration channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pmts_pkg::HOLD_W-1:0]       hold_ticks
);
	import pmts_pkg::*;

	tok_t                 tok   [TABLE_DEPTH+1];  // tok[i] enters cell i
	entry_t               upd   [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] tok_act;
	apply_t               apply;
	cnt_t                 count;
	logic [SAMPLE_W-1:0]  sid;
	logic [HOLD_W-1:0]    hold;

	// sequencer and output register
	pmts_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.func          (func),
		.sample_id     (sample_id),
		.priority_req  (priority_req),
		.player_busy   (player_busy),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.hold_ticks    (hold_ticks),
		.tok_last      (tok[TABLE_DEPTH]),
		.tok_first     (tok[0]),
		.apply         (apply),
		.count         (count),
		.sid           (sid),
		.hold          (hold),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.play_valid    (play_valid),
		.play_id       (play_id),
		.insert_status (insert_status),
		.entry_count   (entry_count)
	);

	// chain of cells: the token runs from cell 0 upwards, removal shifts entries downwards
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		entry_t nbr;

		if (i == TABLE_DEPTH - 1) begin : g_end
			// the top cell has no upper neighbour; its contents fall out of range on removal
			assign nbr = upd[i];
		end else begin : g_mid
			assign nbr = upd[i+1];
		end

		pmts_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IDX_W'(i)),
			.count   (count),
			.hold    (hold),
			.sid     (sid),
			.tok_in  (tok[i]),
			.apply   (apply),
			.nbr_upd (nbr),
			.tok_out (tok[i+1]),
			.upd     (upd[i])
		);

		assign tok_act[i] = tok[i+1].active;
	end

	// only one scan token is ever in flight
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_act))
		else $error("more than one scan token in the chain");

	// fill count stays within the table
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	// an accepted transaction keeps the request side stalled on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while a transaction is still in progress");

	// a play result never carries an insert status
	a_play_vs_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && play_valid) |-> (insert_status == STS_OK))
		else $error("play result with a non-zero insert status");

	// update cycle only happens with the scan finished and the output register free
	a_apply_free: assert property (@(posedge clk) disable iff (!arst_n)
		apply.en |-> !(rsp_valid && rsp_stall))
		else $error("table update while the result is still held");

endmodule

`default_nettype wire
